/* design/wolff_cluster_update_triangular_top_macros.svh */
// Assertion macros used by the design files (wct_stack).
`ifndef WOLFF_CLUSTER_UPDATE_TRIANGULAR_TOP_MACROS_SVH
`define WOLFF_CLUSTER_UPDATE_TRIANGULAR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define WCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wct: assertion failed");
// Next-cycle implication.
`define WCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wct: assertion failed");
`else
`define WCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/wct_pkg.sv */
package wct_pkg;

    localparam int SIDE_DEF   = 16;
    localparam int SITES_DEF  = 256;

    localparam int ROOT_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int SUM_W      = 10;
    localparam int THR_W      = 16;
    localparam int RNG_W      = 32;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [THR_W-1:0] THR_RESET  = 16'd23332;
    localparam logic [RNG_W-1:0] SEED_RESET = 32'd12345;

    typedef enum logic {
        REG_THR,
        REG_SEED
    } t_reg;

    typedef enum logic [2:0] {
        DIR_XP,
        DIR_XM,
        DIR_YP,
        DIR_YM,
        DIR_XPYP,
        DIR_XMYM
    } t_dir;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT_RED,
        ST_ROOT_RD,
        ST_ROOT_WR,
        ST_POP,
        ST_POP_WAIT,
        ST_DIV,
        ST_XRED,
        ST_NB_ADDR,
        ST_NB_RED,
        ST_NB_READ,
        ST_NB_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

/* design/wct_rng.sv */
module wct_rng
    import wct_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [RNG_W-1:0] i_seed,
    input  logic             i_step,
    output logic [RNG_W-1:0] o_next
);

    logic [RNG_W-1:0] r_word;
    logic [RNG_W-1:0] s1;
    logic [RNG_W-1:0] s2;

    always_comb begin
        s1     = r_word ^ (r_word << 13);
        s2     = s1 ^ (s1 >> 17);
        o_next = s2 ^ (s2 << 5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= SEED_RESET;
        end else if (i_load) begin
            // an all-zero state would lock up
            r_word <= (i_seed == '0) ? RNG_W'(1) : i_seed;
        end else if (i_step) begin
            r_word <= o_next;
        end
    end

endmodule

/* design/wct_stack.sv */
`include "wolff_cluster_update_triangular_top_macros.svh"

module wct_stack
    import wct_pkg::*;
#(
    parameter int SITES = SITES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_stk_ctl                 i_ctl,
    input  logic [$clog2(SITES)-1:0] i_wdata,
    output logic [$clog2(SITES)-1:0] o_rdata,
    output logic                     o_empty,
    output logic                     o_full
);

    localparam int SW    = $clog2(SITES);
    localparam int LVL_W = SW + 1;

    logic [SW-1:0]    r_mem [SITES];
    logic [SW-1:0]    r_rdata;
    logic [LVL_W-1:0] r_level;
    logic [LVL_W-1:0] lvl_m1;

    assign lvl_m1  = r_level - LVL_W'(1);
    assign o_empty = (r_level == '0);
    assign o_full  = (r_level == LVL_W'(SITES));
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_ctl.push) begin
            r_level <= r_level + LVL_W'(1);
        end else if (i_ctl.pop) begin
            r_level <= lvl_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_level[SW-1:0]] <= i_wdata;
        end
        if (i_ctl.pop) begin
            r_rdata <= r_mem[lvl_m1[SW-1:0]];
        end
    end

    `WCT_ASSERT_IMP(a_level_bound, i_clk, i_rst_n, 1'b1, r_level <= LVL_W'(SITES))
    `WCT_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_ctl.pop, !o_empty && !i_ctl.push)
    `WCT_ASSERT_NXT(a_push_grows, i_clk, i_rst_n, i_ctl.push, r_level == $past(r_level) + LVL_W'(1))

endmodule

/* design/wct_core.sv */
module wct_core
    import wct_pkg::*;
#(
    parameter int SIDE  = SIDE_DEF,
    parameter int SITES = SITES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ROOT_W-1:0]        i_root_site,
    input  logic [THR_W-1:0]         i_add_threshold,
    input  logic [RNG_W-1:0]         i_rng_next,
    output logic                     o_rng_step,
    output t_stk_ctl                 o_stk_ctl,
    output logic [$clog2(SITES)-1:0] o_stk_wdata,
    input  logic [$clog2(SITES)-1:0] i_stk_rdata,
    input  logic                     i_stk_empty,
    input  logic                     i_stk_full,
    output logic                     o_busy,
    output logic                     o_valid,
    output logic [SIZE_W-1:0]        o_cluster_size,
    output logic signed [SUM_W-1:0]  o_spin_sum
);

    localparam int  SW        = $clog2(SITES);
    localparam int  CW        = $clog2(SIDE);
    localparam int  IW        = $clog2(SIDE * SIDE);
    localparam int  DW0       = (SW > ROOT_W) ? SW : ROOT_W;
    localparam int  DW        = (IW > DW0) ? IW : DW0;
    localparam bit  SIDE_POW2 = ((SIDE & (SIDE - 1)) == 0);
    localparam bit  NEED_RED  = ((SIDE * SIDE) > SITES);

    t_state r_state;
    t_state n_state;

    logic [DW-1:0]     r_acc, n_acc;
    logic [DW-1:0]     r_q, n_q;
    logic [CW-1:0]     r_x, n_x;
    logic [CW-1:0]     r_y, n_y;
    t_dir              r_k, n_k;
    logic              r_old, n_old;
    logic [SIZE_W-1:0] r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SW-1:0]     r_clr, n_clr;

    // spin store: 1 is +1, 0 is -1
    logic          r_spin [SITES];
    logic          r_spin_rd;
    logic          spin_we;
    logic          spin_wdata;
    logic [SW-1:0] spin_waddr;

    // shared subtract/compare unit
    logic          use_sites;
    logic [DW:0]   sub_b;
    logic [DW:0]   sub_d;
    logic          sub_ge;

    logic [CW-1:0] xp, xm, yp, ym, nx, ny;
    logic [IW-1:0] nb_idx;
    logic [DW-1:0] cur;
    logic          bond;

    assign use_sites = (r_state == ST_ROOT_RED) || (r_state == ST_NB_RED);
    assign sub_b     = use_sites ? (DW+1)'(SITES) : (DW+1)'(SIDE);
    assign sub_d     = {1'b0, r_acc} - sub_b;
    assign sub_ge    = !sub_d[DW];

    assign xp = (r_x == CW'(SIDE - 1)) ? '0 : r_x + CW'(1);
    assign xm = (r_x == '0) ? CW'(SIDE - 1) : r_x - CW'(1);
    assign yp = (r_y == CW'(SIDE - 1)) ? '0 : r_y + CW'(1);
    assign ym = (r_y == '0) ? CW'(SIDE - 1) : r_y - CW'(1);

    always_comb begin
        case (r_k)
            DIR_XP:   begin nx = xp;  ny = r_y; end
            DIR_XM:   begin nx = xm;  ny = r_y; end
            DIR_YP:   begin nx = r_x; ny = yp;  end
            DIR_YM:   begin nx = r_x; ny = ym;  end
            DIR_XPYP: begin nx = xp;  ny = yp;  end
            DIR_XMYM: begin nx = xm;  ny = ym;  end
            default:  begin nx = r_x; ny = r_y; end
        endcase
    end

    assign nb_idx = IW'(nx) * IW'(SIDE) + IW'(ny);
    assign cur    = DW'(i_stk_rdata);
    assign bond   = (i_rng_next[THR_W-1:0] < i_add_threshold) && !i_stk_full;

    assign spin_waddr  = (r_state == ST_CLEAR) ? r_clr : r_acc[SW-1:0];
    assign o_stk_wdata = r_acc[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (spin_we) begin
            r_spin[spin_waddr] <= spin_wdata;
        end
        r_spin_rd <= r_spin[r_acc[SW-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:    if (r_clr == SW'(SITES - 1)) n_state = ST_IDLE;
            ST_IDLE:     if (i_start) n_state = ST_ROOT_RED;
            ST_ROOT_RED: if (!sub_ge) n_state = ST_ROOT_RD;
            ST_ROOT_RD:  n_state = ST_ROOT_WR;
            ST_ROOT_WR:  n_state = ST_POP;
            ST_POP:      n_state = i_stk_empty ? ST_DONE : ST_POP_WAIT;
            ST_POP_WAIT: n_state = SIDE_POW2 ? ST_NB_ADDR : ST_DIV;
            ST_DIV:      if (!sub_ge) n_state = ST_XRED;
            ST_XRED:     if (!sub_ge) n_state = ST_NB_ADDR;
            ST_NB_ADDR:  n_state = NEED_RED ? ST_NB_RED : ST_NB_READ;
            ST_NB_RED:   if (!sub_ge) n_state = ST_NB_READ;
            ST_NB_READ:  n_state = ST_NB_CHECK;
            ST_NB_CHECK: n_state = (r_k == DIR_XMYM) ? ST_POP : ST_NB_ADDR;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_acc      = r_acc;
        n_q        = r_q;
        n_x        = r_x;
        n_y        = r_y;
        n_k        = r_k;
        n_old      = r_old;
        n_count    = r_count;
        n_sum      = r_sum;
        n_clr      = r_clr;
        spin_we    = 1'b0;
        spin_wdata = ~r_spin_rd;
        o_stk_ctl  = '0;
        o_rng_step = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                spin_we    = 1'b1;
                spin_wdata = 1'b1;
                n_clr      = r_clr + SW'(1);
            end
            ST_IDLE: begin
                n_acc = DW'(i_root_site);
            end
            ST_ROOT_RED: begin
                if (sub_ge) n_acc = sub_d[DW-1:0];
            end
            ST_ROOT_RD: begin
            end
            ST_ROOT_WR: begin
                n_old          = r_spin_rd;
                spin_we        = 1'b1;
                o_stk_ctl.push = 1'b1;
                n_count        = SIZE_W'(1);
            end
            ST_POP: begin
                if (i_stk_empty) begin
                    n_sum = r_old ? r_sum - {r_count, 1'b0} : r_sum + {r_count, 1'b0};
                end else begin
                    o_stk_ctl.pop = 1'b1;
                end
            end
            ST_POP_WAIT: begin
                n_acc = cur;
                n_q   = '0;
                n_x   = CW'(cur >> CW);
                n_y   = CW'(cur);
                n_k   = DIR_XP;
            end
            ST_DIV: begin
                if (sub_ge) begin
                    n_acc = sub_d[DW-1:0];
                    n_q   = r_q + DW'(1);
                end else begin
                    n_y   = CW'(r_acc);
                    n_acc = r_q;
                end
            end
            ST_XRED: begin
                // quotient x taken modulo SIDE; only a root beyond the lattice needs it
                if (sub_ge) n_acc = sub_d[DW-1:0];
                else        n_x   = CW'(r_acc);
            end
            ST_NB_ADDR: begin
                n_acc = DW'(nb_idx);
            end
            ST_NB_RED: begin
                if (sub_ge) n_acc = sub_d[DW-1:0];
            end
            ST_NB_READ: begin
            end
            ST_NB_CHECK: begin
                if (r_spin_rd == r_old) begin
                    o_rng_step = 1'b1;
                    if (bond) begin
                        spin_we        = 1'b1;
                        o_stk_ctl.push = 1'b1;
                        n_count        = r_count + SIZE_W'(1);
                    end
                end
                n_k = t_dir'(3'(r_k) + 3'd1);
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_sum   <= SUM_W'(SITES);
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_q   <= n_q;
        r_x   <= n_x;
        r_y   <= n_y;
        r_k   <= n_k;
        r_old <= n_old;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_DONE);
    assign o_cluster_size = r_count;
    assign o_spin_sum     = $signed(r_sum);

endmodule

/* design/wolff_cluster_update_triangular_top.sv */
// Wolff cluster flip on a periodic SIDE x SIDE triangular Ising lattice. A transaction
// is accepted when start is high and busy is low; i_root_site names the seed site.
// After reset the spin store is set to +1 by a clearing pass over all SITES sites, busy
// high throughout. When SIDE is a power of two and SIDE*SIDE <= SITES, every
// neighbour check is a serial address, read, test sequence on the single spin
// memory. Other sizes add repeated-subtraction steps for the row/column split and
// for modulo SITES. The result is shown for one cycle with o_valid and cannot be
// stalled by the receiver.
module wolff_cluster_update_triangular_top
    import wct_pkg::*;
#(
    parameter int SIDE  = SIDE_DEF,
    parameter int SITES = SITES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [ROOT_W-1:0]       i_root_site,
    output logic                    o_valid,
    output logic [SIZE_W-1:0]       o_cluster_size,
    output logic signed [SUM_W-1:0] o_spin_sum,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    localparam int SW = $clog2(SITES);

    logic [THR_W-1:0] r_thr;
    logic [RNG_W-1:0] r_seed;
    logic             wr;
    logic             seed_load;
    t_reg             reg_sel;

    logic [RNG_W-1:0] rng_next;
    logic             rng_step;
    t_stk_ctl         stk_ctl;
    logic [SW-1:0]    stk_wdata;
    logic [SW-1:0]    stk_rdata;
    logic             stk_empty;
    logic             stk_full;

    assign pready    = 1'b1;
    assign wr        = psel && penable && pwrite && pready;
    assign reg_sel   = t_reg'(paddr[2]);
    assign seed_load = wr && (reg_sel == REG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_seed <= SEED_RESET;
        end else if (wr) begin
            unique case (reg_sel)
                REG_THR:  r_thr  <= pwdata[THR_W-1:0];
                REG_SEED: r_seed <= pwdata[RNG_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_THR:  prdata = APB_DW'(r_thr);
            REG_SEED: prdata = APB_DW'(r_seed);
            default:  prdata = '0;
        endcase
    end

    wct_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (seed_load),
        .i_seed  (pwdata[RNG_W-1:0]),
        .i_step  (rng_step),
        .o_next  (rng_next)
    );

    wct_stack #(
        .SITES (SITES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .i_wdata (stk_wdata),
        .o_rdata (stk_rdata),
        .o_empty (stk_empty),
        .o_full  (stk_full)
    );

    wct_core #(
        .SIDE  (SIDE),
        .SITES (SITES)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_root_site     (i_root_site),
        .i_add_threshold (r_thr),
        .i_rng_next      (rng_next),
        .o_rng_step      (rng_step),
        .o_stk_ctl       (stk_ctl),
        .o_stk_wdata     (stk_wdata),
        .i_stk_rdata     (stk_rdata),
        .i_stk_empty     (stk_empty),
        .i_stk_full      (stk_full),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_cluster_size  (o_cluster_size),
        .o_spin_sum      (o_spin_sum)
    );

endmodule
